// ----- rtl/gpc_pkg.sv -----
package gpc_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    // board size registers and their reset values
    localparam int CFG_W      = 7;
    localparam int RESET_ROWS = 5;
    localparam int RESET_COLS = 5;

    localparam int COUNT_W = 64;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef enum logic [0:0] {
        REG_ROWS_IN_USE = 1'b0,
        REG_COLS_IN_USE = 1'b1
    } t_reg_idx;

endpackage

// ----- rtl/gpc_ram.sv -----
module gpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_waddr,
    input  logic [WIDTH-1:0]        i_wdata,
    input  logic                    i_re,
    input  logic [AW-1:0]           i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/grid_path_count_with_obstacles_unit.sv -----
// Route counter for a grid streamed in raster order.
// Input channel: i_valid / o_stall with i_blocked, one grid cell per transfer.
// Output channel: o_valid / i_stall with o_route_count, o_saturated and o_last_cell,
// one result per input cell, in order.
// Board size sits in two APB registers: rows at 0x0, columns at 0x4 (pready always high).
// A taken cell is held in a one-entry stage and moves on to the output register
// when that stage advances. Throughput: one cell per cycle unless the receiver stalls.
// The previous row lives in a single line store read when a cell is taken and written
// when its result moves to the output register; each cycle needs a read and a write.
// A result waiting under i_stall does not block intake: the one-entry stage in
// front of the output register still takes a cell, and o_stall rises only when
// both that stage and the output register are full and the receiver stalls.
// Reset (synchronous, active low) clears the position to the start cell, the
// board to 5 by 5 and empties the pipeline. The line store is not cleared; every
// entry is written in the first row before any later row reads it.
module grid_path_count_with_obstacles_unit
    import gpc_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // cell input
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_blocked,
    // result output
    output logic                o_valid,
    input  logic                i_stall,
    output logic [COUNT_W-1:0]  o_route_count,
    output logic                o_saturated,
    output logic                o_last_cell,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int PW0 = (CFG_W > RW) ? CFG_W : RW;
    localparam int PW  = ((PW0 > CW) ? PW0 : CW) + 1;

    typedef struct packed {
        logic [CW-1:0] col;
        logic          first_row;
        logic          first_col;
        logic          last;
        logic          blk;
    } t_stage;

    // configuration registers
    logic [CFG_W-1:0] r_rows_in_use;
    logic [CFG_W-1:0] r_cols_in_use;
    logic             cfg_wr;
    t_reg_idx         reg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = t_reg_idx'(paddr[2]);

    always_comb begin
        unique case (reg_sel)
            REG_ROWS_IN_USE: prdata = APB_DW'(r_rows_in_use);
            REG_COLS_IN_USE: prdata = APB_DW'(r_cols_in_use);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= CFG_W'(RESET_ROWS);
            r_cols_in_use <= CFG_W'(RESET_COLS);
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_ROWS_IN_USE: r_rows_in_use <= pwdata[CFG_W-1:0];
                REG_COLS_IN_USE: r_cols_in_use <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // effective board size: zero acts as one, oversize clips to the maximum
    logic [CFG_W-1:0] eff_rows;
    logic [CFG_W-1:0] eff_cols;

    always_comb begin
        if (r_rows_in_use == '0) begin
            eff_rows = CFG_W'(1);
        end else if (32'(r_rows_in_use) > 32'(MAX_ROWS)) begin
            eff_rows = CFG_W'(MAX_ROWS);
        end else begin
            eff_rows = r_rows_in_use;
        end
        if (r_cols_in_use == '0) begin
            eff_cols = CFG_W'(1);
        end else if (32'(r_cols_in_use) > 32'(MAX_COLS)) begin
            eff_cols = CFG_W'(MAX_COLS);
        end else begin
            eff_cols = r_cols_in_use;
        end
    end

    // position of the next cell
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] cur_row;
    logic [CW-1:0] cur_col;
    logic          col_wrap;
    logic [PW-1:0] row_inc;
    logic [PW-1:0] col_nx;
    logic [PW-1:0] row_nx;
    logic          cur_last;

    always_comb begin
        // a position left beyond a shrunk board moves on to the next row
        col_wrap = PW'(r_col) >= PW'(eff_cols);
        cur_col  = col_wrap ? '0 : r_col;
        row_inc  = PW'(r_row) + PW'(col_wrap);
        cur_row  = (row_inc >= PW'(eff_rows)) ? '0 : row_inc[RW-1:0];
        cur_last = (PW'(cur_row) == PW'(eff_rows) - PW'(1))
                && (PW'(cur_col) == PW'(eff_cols) - PW'(1));

        col_nx = PW'(cur_col) + PW'(1);
        row_nx = PW'(cur_row) + PW'(1);
        if (col_nx >= PW'(eff_cols)) begin
            n_col = '0;
            n_row = (row_nx >= PW'(eff_rows)) ? '0 : row_nx[RW-1:0];
        end else begin
            n_col = col_nx[CW-1:0];
            n_row = cur_row;
        end
    end

    // pipeline control
    logic   in_xfer;
    logic   s1_adv;
    logic   r_s1_valid;
    t_stage r_s1;
    logic   r_out_valid;

    assign s1_adv  = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_adv;
    assign in_xfer = i_valid && !o_stall;

    // line store: previous row's counts with their obstacle bits on top.
    // the only cell in flight ahead of a read sits in a different column,
    // except for one-column boards where the upper count is never used
    logic [COUNT_W:0] line_rdata;
    logic [COUNT_W:0] line_wdata;

    gpc_ram #(
        .WIDTH (COUNT_W + 1),
        .DEPTH (MAX_COLS)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1.col),
        .i_wdata (line_wdata),
        .i_re    (in_xfer),
        .i_raddr (cur_col),
        .o_rdata (line_rdata)
    );

    // count for the cell in the second stage
    logic [COUNT_W-1:0] r_left_cnt;
    logic               r_left_blk;
    logic [COUNT_W-1:0] up_cnt;
    logic [COUNT_W-1:0] left_cnt;
    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] s1_count;
    logic               s1_sat;

    always_comb begin
        up_cnt   = line_rdata[COUNT_W] ? '0 : line_rdata[COUNT_W-1:0];
        left_cnt = r_left_blk ? '0 : r_left_cnt;
        sum      = {1'b0, up_cnt} + {1'b0, left_cnt};
        s1_sat   = 1'b0;
        if (r_s1.first_row && r_s1.first_col) begin
            s1_count = '0;
        end else if (r_s1.first_row || r_s1.first_col) begin
            s1_count = COUNT_W'(1);
        end else if (sum[COUNT_W]) begin
            s1_count = '1;
            s1_sat   = 1'b1;
        end else begin
            s1_count = sum[COUNT_W-1:0];
        end
    end

    assign line_wdata = {r_s1.blk, s1_count};

    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_sat;
    logic               r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_left_cnt  <= '0;
            r_left_blk  <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_row      <= n_row;
                r_col      <= n_col;
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_left_cnt  <= s1_count;
                r_left_blk  <= r_s1.blk;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1.col       <= cur_col;
            r_s1.first_row <= (cur_row == '0);
            r_s1.first_col <= (cur_col == '0);
            r_s1.last      <= cur_last;
            r_s1.blk       <= i_blocked;
        end
        if (s1_adv) begin
            r_out_count <= s1_count;
            r_out_sat   <= s1_sat;
            r_out_last  <= r_s1.last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_route_count = r_out_count;
    assign o_saturated   = r_out_sat;
    assign o_last_cell   = r_out_last;

endmodule

// ----- rtl/gpc_checker.sv -----
module gpc_checker
    import gpc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_stall,
    input  logic                o_valid,
    input  logic                i_stall,
    input  logic [COUNT_W-1:0]  o_route_count,
    input  logic                o_saturated,
    input  logic                o_last_cell
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_route_count)
            && $stable(o_saturated) && $stable(o_last_cell))
        else $error("output changed while stalled");

    // a clipped count is always the all-ones value
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_route_count == '1)
        else $error("saturation flag without maximum count");

    // with the output register free nothing holds back the intake
    a_no_stall_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("intake stalled while output empty");

    // the cell after the final one is the start cell, which counts zero
    a_wrap_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_valid && !i_stall && o_last_cell) && o_valid
            |-> o_route_count == '0 && !o_saturated)
        else $error("start cell after wrap not zero");

endmodule

bind grid_path_count_with_obstacles_unit gpc_checker u_gpc_checker (.*);
